/* src/rmmat_pkg.sv */
package rmmat_pkg;
  localparam int NUM_PROPS = 16;
  localparam int AW = (NUM_PROPS > 1) ? $clog2(NUM_PROPS) : 1;
  localparam int ENTRY_W = 32 + 48 + 32 + 32 + 32 + 1;

  localparam logic [2:0] CMD_SET = 3'd0;
  localparam logic [2:0] CMD_ADD = 3'd1;
  localparam logic [2:0] CMD_EN  = 3'd2;
  localparam logic [2:0] CMD_DIS = 3'd3;
  localparam logic [2:0] CMD_RD  = 3'd4;
  localparam logic [2:0] CMD_CLW = 3'd5;
  localparam logic [2:0] CMD_RST = 3'd6;

  localparam logic [0:0] REG_ACC  = 1'd0;
  localparam logic [0:0] REG_MASK = 1'd1;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [47:0] sum;
    logic [31:0]        count;
    logic signed [31:0] minv;
    logic signed [31:0] maxv;
    logic               en;
  } entry_t;

  typedef struct packed {
    logic        start;
    logic [47:0] num;
    logic [31:0] den;
  } div_req_t;
endpackage

/* src/rmmat_ram.sv */
module rmmat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* src/rmmat_div.sv */
module rmmat_div import rmmat_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  div_req_t    req,
  output logic        done,
  output logic [47:0] quo
);
  logic [47:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [32:0] sh;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    sh = {rem_r[31:0], q_r[47]};
    if (req.start) begin
      q_nxt = req.num;
      rem_nxt = '0;
      cnt_nxt = 6'd48;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = sh - {1'b0, den_r};
        q_nxt = {q_r[46:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt = {q_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (req.start) den_r <= req.den;
  end

  assign done = busy_r && cnt_r == 6'd1;
  assign quo = q_nxt;
endmodule

/* src/running_min_max_average_table_core.sv */
// A request for one entry is read, updated and written back, then sent out; a defined
// entry with a nonzero count adds a pass through the bit-serial divider. Clear window and
// reset all first walk the whole table. Only one request is taken at a time: in_stall is
// high outside idle, and the bit-serial divider and the entry walk hold it there.
// Reset: synchronous active low; a clearing pass over all NUM_PROPS entries runs after reset,
// during which no request is taken. Registers return to accumulate 0, mask 0xFF.
module running_min_max_average_table_core import rmmat_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_cmd,
  input  logic [7:0]         in_prop,
  input  logic signed [31:0] in_val,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_status,
  output logic signed [31:0] out_cur_value,
  output logic signed [31:0] out_average,
  output logic signed [31:0] out_min_value,
  output logic signed [31:0] out_max_value,
  output logic [31:0]        out_sample_total,
  output logic               out_shown,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam logic [2:0] S_WALK = 3'd6;
  localparam logic [2:0] S_WRD  = 3'd7;

  logic [2:0]  st_r, st_nxt;
  logic        acc_r;
  logic [15:0] mask_r;
  logic [2:0]  cmd_r;
  logic [AW-1:0] p_r, wp_r;
  logic        ok_r;
  logic signed [31:0] val_r;
  entry_t      ent_r, rd_ent, wr_ent, nw;
  logic        we, done;
  logic [AW-1:0] waddr, raddr;
  logic [AW:0] walk_r;
  logic        walk_last;
  div_req_t    dreq;
  logic [47:0] quo;
  logic        neg_r;
  logic signed [31:0] avg_r;
  logic        ovalid_r;
  logic signed [48:0] s49;
  logic signed [32:0] v33;
  logic signed [47:0] sumn;
  logic signed [31:0] valn;
  logic [47:0] mag;
  logic        fw_we_r;
  logic [AW-1:0] fw_addr_r;
  entry_t      fw_ent_r;

  function automatic logic def(input logic [15:0] m, input logic [AW-1:0] i);
    logic [15:0] ix;
    ix = 16'(i);
    return (int'(i) < 16) && m[ix[3:0]];
  endfunction

  rmmat_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_PROPS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wr_ent), .raddr(raddr), .rdata(rd_ent)
  );

  rmmat_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(done), .quo(quo));

  assign in_stall = st_r != S_IDLE;
  assign walk_last = walk_r[AW-1:0] == AW'(NUM_PROPS - 1);
  assign raddr = (st_r == S_IDLE) ? in_prop[AW-1:0] :
                 (st_nxt == S_RD) ? p_r : walk_r[AW-1:0];

  always_comb begin
    nw = ent_r;
    s49 = 49'(ent_r.sum) + 49'(val_r);
    sumn = (s49 > 49'sh0_7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF :
           (s49 < -49'sh0_8000_0000_0000) ? -48'sh8000_0000_0000 : s49[47:0];
    v33 = 33'(ent_r.value) + 33'(val_r);
    valn = (v33 > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
           (v33 < -33'sh0_8000_0000) ? -32'sh8000_0000 : v33[31:0];
    unique case (cmd_r)
      CMD_SET: begin
        if (acc_r) begin
          if (ent_r.count != '1) nw.count = ent_r.count + 32'd1;
          nw.sum = sumn;
        end else begin
          nw.count = 32'd1;
          nw.sum = 48'(val_r);
        end
        nw.value = val_r;
      end
      CMD_ADD: begin
        nw.value = valn;
        nw.sum = sumn;
      end
      CMD_EN:  nw.en = 1'b1;
      CMD_DIS: nw.en = 1'b0;
      default: ;
    endcase
    if (cmd_r == CMD_SET || cmd_r == CMD_ADD) begin
      if (ent_r.minv == 0 || ent_r.minv > nw.value) nw.minv = nw.value;
      if (ent_r.maxv < nw.value) nw.maxv = nw.value;
    end
  end

  always_comb begin
    we = 1'b0;
    waddr = wp_r;
    wr_ent = nw;
    if (st_r == S_CLR || (st_r == S_WALK && cmd_r == CMD_RST)) begin
      we = 1'b1;
      waddr = walk_r[AW-1:0];
      wr_ent = '0;
      wr_ent.en = walk_r == '0;
    end else if (st_r == S_WRD && cmd_r == CMD_CLW) begin
      we = def(mask_r, wp_r);
      wr_ent = rd_ent;
      wr_ent.sum = '0;
      wr_ent.count = '0;
    end else if (st_r == S_MOD) begin
      we = ok_r;
      waddr = p_r;
    end
    mag = nw.sum[47] ? 48'(-nw.sum) : 48'(nw.sum);
    dreq.start = st_r == S_MOD && ok_r && nw.count != 0;
    dreq.num = mag;
    dreq.den = nw.count;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_CLR:  if (walk_last) st_nxt = S_IDLE;
      S_IDLE: if (in_valid) st_nxt = (in_cmd == CMD_CLW) ? S_WRD :
                                     (in_cmd == CMD_RST) ? S_WALK : S_RD;
      S_RD:   st_nxt = S_MOD;
      S_MOD:  st_nxt = dreq.start ? S_DIV : S_OUT;
      S_DIV:  if (done) st_nxt = S_OUT;
      S_OUT:  if (!out_stall) st_nxt = S_IDLE;
      S_WALK: if (walk_last) st_nxt = S_RD;
      S_WRD:  if (wp_r == AW'(NUM_PROPS - 1)) st_nxt = S_RD;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      acc_r <= 1'b0;
      mask_r <= 16'h00FF;
      walk_r <= '0;
      ovalid_r <= 1'b0;
      fw_we_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      fw_we_r <= we;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ACC:  acc_r <= cfg_data[0];
          REG_MASK: mask_r <= cfg_data;
          default: ;
        endcase
      end
      if (st_r == S_CLR || st_r == S_WALK || st_r == S_WRD) walk_r <= walk_r + 1'b1;
      else walk_r <= '0;
      if (st_nxt == S_OUT && st_r != S_OUT) ovalid_r <= 1'b1;
      else if (st_r == S_OUT && !out_stall) ovalid_r <= 1'b0;
    end
    if (st_r == S_IDLE && in_valid) begin
      cmd_r <= in_cmd;
      p_r <= in_prop[AW-1:0];
      val_r <= in_val;
      ok_r <= (32'(in_prop) < NUM_PROPS) && (in_prop < 8'd16) && mask_r[in_prop[3:0]];
    end
    wp_r <= walk_r[AW-1:0];
    fw_addr_r <= waddr;
    fw_ent_r <= wr_ent;
    if (st_r == S_RD) ent_r <= (fw_we_r && fw_addr_r == p_r) ? fw_ent_r : rd_ent;
    if (st_r == S_MOD) begin
      ent_r <= nw;
      neg_r <= nw.sum[47];
      avg_r <= '0;
    end
    if (st_r == S_DIV && done) begin
      if (quo > 48'h7FFF_FFFF)
        avg_r <= neg_r ? ((quo > 48'h8000_0000) ? -32'sh8000_0000 : -32'(quo)) : 32'sh7FFF_FFFF;
      else
        avg_r <= neg_r ? -32'(quo) : 32'(quo);
    end
  end

  assign out_valid = ovalid_r;
  assign out_status = !ok_r;
  assign out_cur_value = ok_r ? ent_r.value : '0;
  assign out_average = ok_r ? avg_r : '0;
  assign out_min_value = ok_r ? ent_r.minv : '0;
  assign out_max_value = ok_r ? ent_r.maxv : '0;
  assign out_sample_total = ok_r ? ent_r.count : '0;
  assign out_shown = ok_r & ent_r.en;
endmodule

/* verif/testbench.sv */
module testbench;
  import rmmat_pkg::*;

  localparam int LAT = 5 + 48 + NUM_PROPS + 8;
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_cmd = '0;
  logic [7:0]         in_prop = '0;
  logic signed [31:0] in_val = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_status;
  logic signed [31:0] out_cur_value;
  logic signed [31:0] out_average;
  logic signed [31:0] out_min_value;
  logic signed [31:0] out_max_value;
  logic [31:0]        out_sample_total;
  logic               out_shown;
  logic               cfg_we = 1'b0;
  logic [0:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  running_min_max_average_table_core dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  typedef struct packed {
    logic               status;
    logic signed [31:0] cur_value;
    logic signed [31:0] average;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic [31:0]        sample_total;
    logic               shown;
  } stats_t;

  stats_t expected_stats[$];
  int errors = 0;
  int hold_cycles = 0;
  bit stall_random = 1'b1;

  logic               acc_mode;
  logic [15:0]        prop_mask;
  logic signed [31:0] m_value[NUM_PROPS];
  logic signed [47:0] m_sum[NUM_PROPS];
  logic [31:0]        m_count[NUM_PROPS];
  logic signed [31:0] m_min[NUM_PROPS];
  logic signed [31:0] m_max[NUM_PROPS];
  logic               m_en[NUM_PROPS];

  function automatic bit prop_defined(logic [7:0] p);
    return p < NUM_PROPS && p < 16 && prop_mask[p[3:0]];
  endfunction

  function automatic void wipe_table();
    for (int i = 0; i < NUM_PROPS; i++) begin
      m_value[i] = 0; m_sum[i] = 0; m_count[i] = 0;
      m_min[i] = 0; m_max[i] = 0; m_en[i] = 1'b0;
    end
    m_en[0] = 1'b1;
  endfunction

  function automatic logic signed [47:0] sat48(logic signed [48:0] x);
    if (x > 49'sd140737488355327) return 48'sh7FFF_FFFF_FFFF;
    if (x < -49'sd140737488355328) return 48'sh8000_0000_0000;
    return x[47:0];
  endfunction

  function automatic void track(int p);
    if (m_min[p] == 0 || m_min[p] > m_value[p]) m_min[p] = m_value[p];
    if (m_max[p] < m_value[p]) m_max[p] = m_value[p];
  endfunction

  function automatic logic signed [31:0] mean_of(int p);
    logic [47:0] mag;
    logic [47:0] q;
    logic signed [49:0] r;
    if (m_count[p] == 0) return 0;
    mag = m_sum[p] < 0 ? -m_sum[p] : m_sum[p];
    q = mag / m_count[p];
    r = m_sum[p] < 0 ? -$signed({2'b0, q}) : $signed({2'b0, q});
    if (r > 50'sd2147483647) return 32'sh7FFF_FFFF;
    if (r < -50'sd2147483648) return 32'sh8000_0000;
    return r[31:0];
  endfunction

  function automatic stats_t update_stats(logic [2:0] cmd, logic [7:0] prop,
                                          logic signed [31:0] v);
    bit ok;
    int p;
    logic signed [32:0] nv;
    stats_t r;
    ok = prop_defined(prop);
    p = prop % NUM_PROPS;
    r = '0;
    if (cmd == CMD_CLW) begin
      for (int i = 0; i < NUM_PROPS; i++)
        if (prop_defined(8'(i))) begin
          m_sum[i] = 0; m_count[i] = 0;
        end
    end else if (cmd == CMD_RST) begin
      wipe_table();
    end else if (ok) begin
      case (cmd)
        CMD_SET: begin
          if (acc_mode) begin
            if (m_count[p] != 32'hFFFF_FFFF) m_count[p]++;
            m_sum[p] = sat48(m_sum[p] + v);
          end else begin
            m_count[p] = 1;
            m_sum[p] = v;
          end
          m_value[p] = v;
          track(p);
        end
        CMD_ADD: begin
          nv = m_value[p] + v;
          if (nv > 33'sd2147483647) m_value[p] = 32'sh7FFF_FFFF;
          else if (nv < -33'sd2147483648) m_value[p] = 32'sh8000_0000;
          else m_value[p] = nv[31:0];
          m_sum[p] = sat48(m_sum[p] + v);
          track(p);
        end
        CMD_EN: m_en[p] = 1'b1;
        CMD_DIS: m_en[p] = 1'b0;
        default: ;
      endcase
    end
    if (ok) begin
      r.cur_value = m_value[p];
      r.average = mean_of(p);
      r.min_value = m_min[p];
      r.max_value = m_max[p];
      r.sample_total = m_count[p];
      r.shown = m_en[p];
    end else begin
      r.status = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    stats_t got;
    stats_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_status, out_cur_value, out_average, out_min_value, out_max_value,
              out_sample_total, out_shown};
      if (expected_stats.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_stats.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (stall_random) begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  int burst_left = 0;

  task automatic send_request(logic [2:0] cmd, logic [7:0] prop, logic signed [31:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_prop <= prop;
    in_val <= v;
    expected_stats.push_back(update_stats(cmd, prop, v));
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (expected_stats.size() == 0);
    repeat (LAT) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] data);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ACC) acc_mode = data[0];
    else prop_mask = data;
  endtask

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $signed($urandom_range(0, 400)) - 200;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] rand_prop();
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return 8'($urandom_range(0, NUM_PROPS - 1));
  endfunction

  task automatic test_directed();
    send_request(CMD_RD, 0, 0);
    send_request(CMD_SET, 1, 32'sh7FFF_FFFF);
    send_request(CMD_ADD, 1, 32'sh7FFF_FFFF);
    send_request(CMD_SET, 2, 32'sh8000_0000);
    send_request(CMD_ADD, 2, 32'sh8000_0000);
    send_request(CMD_SET, 3, 0);
    send_request(CMD_SET, 3, -5);
    send_request(CMD_EN, 4, 0);
    send_request(CMD_DIS, 0, 0);
    send_request(CMD_RD, 8, 1);
    send_request(CMD_RD, 8'hFF, 32'hFFFF_FFFF);
    send_request(CMD_SET, 16, 7);
    send_request(CMD_UNUSED, 1, 0);
    send_request(CMD_CLW, 1, 0);
    send_request(CMD_RD, 2, 0);
    send_request(CMD_RST, 9, 0);
    send_request(CMD_RD, 1, 0);
  endtask

  task automatic test_accumulate();
    write_reg(REG_ACC, 1);
    write_reg(REG_MASK, 16'hFFFF);
    for (int i = 0; i < 20; i++) send_request(CMD_SET, 5, 32'sh7FFF_FFFF);
    for (int i = 0; i < 20; i++) send_request(CMD_SET, 6, 32'sh8000_0000);
    send_request(CMD_ADD, 7, 3);
    send_request(CMD_RD, 15, 0);
  endtask

  task automatic test_random(int n);
    logic [2:0] c;
    for (int i = 0; i < n; i++) begin
      c = 3'($urandom_range(0, 7));
      if (c >= CMD_CLW && $urandom_range(0, 5) != 0) c = CMD_SET;
      send_request(c, rand_prop(), rand_val());
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_cycles = 400;
    for (int i = 0; i < 30; i++) send_request(CMD_SET, rand_prop(), rand_val());
    stall_random = 1'b0;
    test_random(60);
    stall_random = 1'b1;
  endtask

  initial begin
    acc_mode = 1'b0;
    prop_mask = 16'h00FF;
    wipe_table();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_accumulate();
    test_random(300);
    write_reg(REG_MASK, 16'h0000);
    test_random(60);
    write_reg(REG_MASK, 16'hA5C3);
    write_reg(REG_ACC, 0);
    test_random(300);
    test_backpressure();
    write_reg(REG_ACC, 1);
    write_reg(REG_MASK, 16'h5A3C);
    test_random(300);
    write_reg(REG_MASK, 16'hFFFF);
    test_random(300);
    drain();
    if (errors == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench: FAIL");
    $finish;
  end
endmodule
